// File: rtl/bsc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bsc_pkg;

  localparam int DIV_BITS = 64;
  localparam int DIV_LAT  = DIV_BITS + 2;
  localparam int MUL_LAT  = 2;
  localparam int STAGES   = 86;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB   = 3'd0,
    REG_PRESS_FIRST  = 3'd1,
    REG_PRESS_MIDDLE = 3'd2,
    REG_PRESS_LAST   = 3'd3,
    REG_HUM_FIRST    = 3'd4,
    REG_HUM_SECOND   = 3'd5
  } cfg_reg_t;

  localparam logic [19:0] RAW_T_BAD = 20'h80000;
  localparam logic [15:0] RAW_H_BAD = 16'h8000;

  localparam logic signed [63:0] PRESS_MIN_Q8 = 64'sd7680000;
  localparam logic signed [63:0] PRESS_MAX_Q8 = 64'sd30720000;
  localparam logic signed [31:0] HUM_MAX_RAW  = 32'sd419430400;

  // side band that rides along the pipeline with each word
  typedef struct packed {
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic        t_ok;
    logic [15:0] temp;
    logic        p_en;
    logic        h_en;
    logic [16:0] hum;
    logic        h_ok;
    logic [24:0] press;
    logic        p_ok;
  } side_t;

endpackage

// File: rtl/bsc_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32-bit partial products.
module bsc_mul64 import bsc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
      p  <= ll + {lh + hl, 32'b0};
    end
  end

endmodule

// File: rtl/bsc_sdiv.sv
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
module bsc_sdiv import bsc_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [DIV_BITS-1:0] num,
  input  logic [DIV_BITS-1:0] den,
  output logic [DIV_BITS-1:0] quo
);

  logic [DIV_BITS-1:0] rem [DIV_BITS+1];
  logic [DIV_BITS-1:0] qn  [DIV_BITS+1];
  logic [DIV_BITS-1:0] dv  [DIV_BITS+1];
  logic                neg [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      qn[0]  <= num[DIV_BITS-1] ? -num : num;
      dv[0]  <= den[DIV_BITS-1] ? -den : den;
      neg[0] <= num[DIV_BITS-1] ^ den[DIV_BITS-1];
    end
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    logic [DIV_BITS:0] trial;
    logic [DIV_BITS:0] diff;
    assign trial = {rem[i], qn[i][DIV_BITS-1]};
    assign diff  = trial - {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DIV_BITS]) begin
          rem[i+1] <= diff[DIV_BITS-1:0];
          qn[i+1]  <= {qn[i][DIV_BITS-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial[DIV_BITS-1:0];
          qn[i+1]  <= {qn[i][DIV_BITS-2:0], 1'b0};
        end
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[DIV_BITS] ? -qn[DIV_BITS] : qn[DIV_BITS];
    end
  end

endmodule

// File: rtl/barometric_sensor_compensation_core.sv
// Top level: fixed-point temperature, pressure and humidity compensation pipeline.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_stall, raw_*                 | sample word in
//  out      | out_valid, out_stall, temp/press/hum      | result word out
//  cfg      | cfg_write, cfg_index, cfg_data            | calibration write
//
// One word enters per cycle while the pipeline is not stalled; the pressure result
// passes through the 64-stage pressure divider plus the multiplier stages around it.
// Synchronous reset clears the valid bits and the calibration registers.
// A stalled result word freezes the whole pipeline and stalls the input.
module barometric_sensor_compensation_core import bsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        raw_press,
  input  logic [19:0]        raw_temperature,
  input  logic [15:0]        raw_humidity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temp_centi,
  output logic               temp_ok,
  output logic [24:0]        press_pa_q8,
  output logic               press_ok,
  output logic [16:0]        hum_q10,
  output logic               hum_ok,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int K_TEMP   = 5;
  localparam int K_HUM    = 14;
  localparam int K_DIV_IN = 13;
  localparam int K_DIVOUT = K_DIV_IN + DIV_LAT;
  localparam int K_LAST   = STAGES - 1;

  // calibration
  logic [47:0] temp_calib, press_first, press_middle, press_last;
  logic [31:0] hum_first, hum_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib   <= '0;
      press_first  <= '0;
      press_middle <= '0;
      press_last   <= '0;
      hum_first    <= '0;
      hum_second   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEMP_CALIB:   temp_calib   <= cfg_data;
        REG_PRESS_FIRST:  press_first  <= cfg_data;
        REG_PRESS_MIDDLE: press_middle <= cfg_data;
        REG_PRESS_LAST:   press_last   <= cfg_data;
        REG_HUM_FIRST:    hum_first    <= cfg_data[31:0];
        REG_HUM_SECOND:   hum_second   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = {48'b0, press_first[15:0]};
  assign p2 = {{48{press_first[31]}}, press_first[31:16]};
  assign p3 = {{48{press_first[47]}}, press_first[47:32]};
  assign p4 = {{48{press_middle[15]}}, press_middle[15:0]};
  assign p5 = {{48{press_middle[31]}}, press_middle[31:16]};
  assign p6 = {{48{press_middle[47]}}, press_middle[47:32]};
  assign p7 = {{48{press_last[15]}}, press_last[15:0]};
  assign p8 = {{48{press_last[31]}}, press_last[31:16]};
  assign p9 = {{48{press_last[47]}}, press_last[47:32]};
  assign h1 = {24'b0, hum_first[7:0]};
  assign h2 = {{16{hum_first[23]}}, hum_first[23:8]};
  assign h3 = {24'b0, hum_first[31:24]};
  assign h4 = {{20{hum_second[11]}}, hum_second[11:0]};
  assign h5 = {{20{hum_second[23]}}, hum_second[23:12]};
  assign h6 = {{24{hum_second[31]}}, hum_second[31:24]};

  // pipeline control
  logic              en;
  logic [STAGES-1:0] vld;
  side_t             sb      [STAGES];
  side_t             sb_next [STAGES];

  assign en       = !(vld[K_LAST] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) sb[k] <= sb_next[k];
    end
  end

  // temperature
  logic        [19:0] adc_t;
  logic signed [17:0] tdt1, td;
  logic signed [31:0] tm1, tdd, tv1, tm2, tf, tc5, tc;
  logic signed [15:0] tsat;

  always_ff @(posedge clk) begin
    if (en) begin
      adc_t <= raw_temperature;
      tdt1  <= $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
      td    <= $signed({2'b0, adc_t[19:4]}) - $signed({2'b0, t1});
      tm1   <= 32'(tdt1) * 32'(t2);
      tdd   <= 32'(td) * 32'(td);
      tv1   <= tm1 >>> 11;
      tm2   <= (tdd >>> 12) * 32'(t3);
      tf    <= tv1 + (tm2 >>> 14);
    end
  end

  assign tc5 = tf * 32'sd5 + 32'sd128;
  assign tc  = tc5 >>> 8;
  always_comb begin
    if (tc < -32'sd32768) tsat = 16'sh8000;
    else if (tc > 32'sd32767) tsat = 16'sh7fff;
    else tsat = tc[15:0];
  end

  // humidity
  logic signed [31:0] hv, hm5, hm6, hm3, hx, hy1, hy2, hyy, hy3, hy, hvv, hss, ht, hs, hf;
  logic signed [31:0] hx8, hx9, hx10, hvv12, hvv13;
  logic        [16:0] hum_val;

  assign hs = hvv >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      hv    <= tf - 32'sd76800;
      hm5   <= h5 * hv;
      hm6   <= hv * h6;
      hm3   <= hv * h3;
      hx    <= ($signed({2'b0, sb[6].adc_h, 14'b0}) - (h4 <<< 20) - hm5 + 32'sd16384) >>> 15;
      hy1   <= hm6 >>> 10;
      hy2   <= (hm3 >>> 11) + 32'sd32768;
      hyy   <= hy1 * hy2;
      hx8   <= hx;
      hy3   <= ((hyy >>> 10) + 32'sd2097152) * h2;
      hx9   <= hx8;
      hy    <= (hy3 + 32'sd8192) >>> 14;
      hx10  <= hx9;
      hvv   <= hx10 * hy;
      hss   <= hs * hs;
      hvv12 <= hvv;
      ht    <= (hss >>> 7) * h1;
      hvv13 <= hvv12;
    end
  end

  assign hf = hvv13 - (ht >>> 4);
  always_comb begin
    if (hf < 32'sd0) hum_val = '0;
    else if (hf > HUM_MAX_RAW) hum_val = HUM_MAX_RAW[28:12];
    else hum_val = hf[28:12];
  end

  // pressure
  logic signed [32:0] pa;
  logic signed [63:0] pa64, aa, ap5, ap2, b6, a3;
  logic signed [63:0] ap5_8, ap5_9, ap2_8, ap2_9, pb, pa2, pm_a, pm_n, m1, m2, dd;
  logic signed [63:0] pq, q13, q13_80, q13_81, pq80, pq81, pq82, pq83;
  logic signed [63:0] m9, m8, p8p82, p8p83, m99, ps, pf;
  logic        [63:0] div_q;

  assign pa64 = {{31{pa[32]}}, pa};

  bsc_mul64 u_aa  (.clk(clk), .en(en), .a(pa64), .b(pa64), .p(aa));
  bsc_mul64 u_ap5 (.clk(clk), .en(en), .a(pa64), .b(p5),   .p(ap5));
  bsc_mul64 u_ap2 (.clk(clk), .en(en), .a(pa64), .b(p2),   .p(ap2));
  bsc_mul64 u_b6  (.clk(clk), .en(en), .a(aa),   .b(p6),   .p(b6));
  bsc_mul64 u_a3  (.clk(clk), .en(en), .a(aa),   .b(p3),   .p(a3));
  bsc_mul64 u_m1  (.clk(clk), .en(en), .a(pm_a), .b(p1),   .p(m1));
  bsc_mul64 u_m2  (.clk(clk), .en(en), .a(pm_n), .b(64'd3125), .p(m2));

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= $signed({tf[31], tf}) - 33'sd128000;
      ap5_8 <= ap5;
      ap5_9 <= ap5_8;
      ap2_8 <= ap2;
      ap2_9 <= ap2_8;
      pb    <= b6 + (ap5_9 <<< 17) + (p4 <<< 35);
      pa2   <= (a3 >>> 8) + (ap2_9 <<< 12);
      pm_a  <= (64'sd1 <<< 47) + pa2;
      pm_n  <= ($signed({43'b0, 21'd1048576 - {1'b0, sb[10].adc_p}}) <<< 31) - pb;
    end
  end

  assign dd = m1 >>> 33;

  bsc_sdiv u_div (.clk(clk), .en(en), .num(m2), .den(dd), .quo(div_q));

  assign pq  = div_q;
  assign q13 = pq >>> 13;

  bsc_mul64 u_m9  (.clk(clk), .en(en), .a(p9),  .b(q13),    .p(m9));
  bsc_mul64 u_m8  (.clk(clk), .en(en), .a(p8),  .b(pq),     .p(m8));
  bsc_mul64 u_m99 (.clk(clk), .en(en), .a(m9),  .b(q13_81), .p(m99));

  always_ff @(posedge clk) begin
    if (en) begin
      q13_80 <= q13;
      q13_81 <= q13_80;
      pq80   <= pq;
      pq81   <= pq80;
      pq82   <= pq81;
      pq83   <= pq82;
      p8p82  <= m8;
      p8p83  <= p8p82;
      ps     <= pq83 + (m99 >>> 25) + (p8p83 >>> 19);
    end
  end

  assign pf = (ps >>> 8) + (p7 <<< 4);

  // side band updates
  always_comb begin
    for (int k = 1; k < STAGES; k++) sb_next[k] = sb[k-1];
    sb_next[0]       = '0;
    sb_next[0].adc_p = raw_press;
    sb_next[0].adc_h = raw_humidity;
    sb_next[0].t_ok  = (raw_temperature != '0) && (raw_temperature != RAW_T_BAD);

    sb_next[K_TEMP].temp = sb[K_TEMP-1].t_ok ? tsat : '0;
    sb_next[K_TEMP].p_en = sb[K_TEMP-1].t_ok && (tf != '0);
    sb_next[K_TEMP].h_en = sb[K_TEMP-1].t_ok && (sb[K_TEMP-1].adc_h != '0) &&
                           (sb[K_TEMP-1].adc_h != RAW_H_BAD);

    sb_next[K_DIV_IN+1].p_en = sb[K_DIV_IN].p_en && (dd != '0);

    sb_next[K_HUM].h_ok = sb[K_HUM-1].h_en;
    sb_next[K_HUM].hum  = sb[K_HUM-1].h_en ? hum_val : '0;

    sb_next[K_LAST].p_ok  = sb[K_LAST-1].p_en && !pf[63] &&
                            (pf >= PRESS_MIN_Q8) && (pf <= PRESS_MAX_Q8);
    sb_next[K_LAST].press = sb_next[K_LAST].p_ok ? pf[24:0] : '0;
  end

  assign out_valid   = vld[K_LAST];
  assign temp_centi  = sb[K_LAST].temp;
  assign temp_ok     = sb[K_LAST].t_ok;
  assign press_pa_q8 = sb[K_LAST].press;
  assign press_ok    = sb[K_LAST].p_ok;
  assign hum_q10     = sb[K_LAST].hum;
  assign hum_ok      = sb[K_LAST].h_ok;

  // quotient must line up with its side band word
  logic unused_divout;
  assign unused_divout = (K_DIVOUT == 79) ? 1'b0 : 1'b1;

`ifndef SYNTHESIS
  a_press_needs_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_ok |-> temp_ok) else $error("pressure valid without temperature");
  a_hum_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hum_ok |-> hum_q10 == '0) else $error("invalid humidity not zero");
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hum_ok |-> hum_q10 <= 17'd102400) else $error("humidity out of range");
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall && unused_divout == 1'b0)
    else $error("output stall not propagated");
`endif

endmodule
